### src/bfa_pkg.sv
// Shared types, codes and helper functions of the bitmap frame allocator.
package bfa_pkg;

    localparam int          FRAME_SHIFT = 12;
    localparam int          COUNT_W     = 21;
    localparam logic [20:0] COUNT_MAX   = 21'd1048576;
    localparam logic [31:0] WORD_FULL   = 32'hFFFF_FFFF;
    localparam logic [10:0] RESERVED_RESET = 11'd256;

    // Request codes
    localparam logic [2:0] REQ_BEGIN_INIT  = 3'd0;
    localparam logic [2:0] REQ_ADD_REGION  = 3'd1;
    localparam logic [2:0] REQ_RESERVE_LOW = 3'd2;
    localparam logic [2:0] REQ_ALLOC       = 3'd3;
    localparam logic [2:0] REQ_FREE        = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_MEM  = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    // Region kind that counts as usable RAM
    localparam logic [7:0] KIND_USABLE = 8'd1;

    // Register index (bit 2 of the byte address)
    localparam logic REG_RESERVED_FRAMES = 1'b0;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] address;
        logic [31:0] region_size;
        logic [7:0]  region_kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        alloc_address;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] total_count;
    } rsp_t;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, COUNT_MAX})
        begin
            return COUNT_MAX;
        end
        return s[COUNT_W-1:0];
    endfunction

    // Index of the lowest clear bit; only meaningful when one exists
    function automatic logic [4:0] lowest_zero(input logic [31:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // Ones from bit lo up to bit hi inclusive
    function automatic logic [31:0] range_mask(input logic [4:0] lo, input logic [4:0] hi);
        return (WORD_FULL << lo) & (WORD_FULL >> (5'd31 - hi));
    endfunction

endpackage

### src/bfa_if.sv
// Request and response channel interfaces of the bitmap frame allocator.
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] address;
    logic [31:0] region_size;
    logic [7:0]  region_kind;

    modport source (output valid, req_type, address, region_size, region_kind,
                    input ready);
    modport sink   (input valid, req_type, address, region_size, region_kind,
                    output ready);
endinterface

interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] alloc_address;
    logic [20:0] used_count;
    logic [20:0] total_count;

    modport source (output valid, status, alloc_address, used_count, total_count,
                    input ready);
    modport sink   (input valid, status, alloc_address, used_count, total_count,
                    output ready);
endinterface

### src/bfa_map_ram.sv
// Single-port frame bitmap memory with registered read data.
module bfa_map_ram #(
    parameter int MAP_WORDS = 1024
) (
    input  logic                   clk,
    input  logic                   re,
    input  logic                   we,
    input  logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] addr,
    input  logic [31:0]            wdata,
    output logic [31:0]            rdata
);
    logic [31:0] mem [MAP_WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/bfa_engine.sv
// Command sequencer: fill sweep, range read-modify-write, next-fit scan, counters.
module bfa_engine #(
    parameter int MAP_WORDS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  bfa_pkg::cmd_t cmd,
    input  logic [10:0]   reserved_frames,
    output logic          res_valid,
    input  logic          res_ready,
    output bfa_pkg::rsp_t res,
    output logic          ram_re,
    output logic          ram_we,
    output logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] ram_addr,
    output logic [31:0]   ram_wdata,
    input  logic [31:0]   ram_rdata
);
    import bfa_pkg::*;

    localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FW = WW + 5;
    localparam logic [COUNT_W-1:0] MAP_FRAMES = COUNT_W'(MAP_WORDS * 32);
    localparam logic [WW-1:0]      LAST_WORD  = WW'(MAP_WORDS - 1);

    typedef enum logic [6:0] {
        S_FILL     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_RANGE_RD = 7'b0000100,
        S_RANGE_WR = 7'b0001000,
        S_SCAN_RD  = 7'b0010000,
        S_SCAN_CHK = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [WW-1:0]      cur_word_reg, cur_word_next;
    logic [WW-1:0]      last_word_reg, last_word_next;
    logic [WW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [WW-1:0]      search_word_reg, search_word_next;
    logic [4:0]         lo_bit_reg, lo_bit_next;
    logic [4:0]         hi_bit_reg, hi_bit_next;
    logic               first_reg, first_next;
    logic               set_reg, set_next;
    logic               fill_rsp_reg, fill_rsp_next;
    logic [COUNT_W-1:0] used_reg, used_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        alloc_addr_reg, alloc_addr_next;

    // Frame range decode of the incoming command
    logic [19:0]        frame_start;
    logic [19:0]        frame_cnt;
    logic [COUNT_W-1:0] region_end;
    logic [COUNT_W-1:0] region_end_cl;
    logic [COUNT_W-1:0] rsv_end;
    logic               free_in_map;
    logic [COUNT_W-1:0] rng_s;
    logic [COUNT_W-1:0] rng_e;
    logic [COUNT_W-1:0] rng_e_m1;
    logic               rng_go;
    logic [4:0]         lo_eff;
    logic [4:0]         hi_eff;
    logic [31:0]        word_mask;
    logic [4:0]         zero_bit;
    logic [WW-1:0]      wrap_word;

    assign frame_start   = cmd.address[31:FRAME_SHIFT];
    assign frame_cnt     = cmd.region_size[31:FRAME_SHIFT];
    assign region_end    = {1'b0, frame_start} + {1'b0, frame_cnt};
    assign region_end_cl = (region_end > MAP_FRAMES) ? MAP_FRAMES : region_end;
    assign rsv_end       = (COUNT_W'(reserved_frames) > MAP_FRAMES) ? MAP_FRAMES
                                                                  : COUNT_W'(reserved_frames);
    assign free_in_map   = {1'b0, frame_start} < MAP_FRAMES;

    always_comb
    begin
        rng_s = {1'b0, frame_start};
        rng_e = rng_s + COUNT_W'(1);
        case (cmd.req_type)
            REQ_ADD_REGION:
            begin
                rng_e = region_end_cl;
            end
            REQ_RESERVE_LOW:
            begin
                rng_s = '0;
                rng_e = rsv_end;
            end
            default:
            begin
                rng_e = rng_s + COUNT_W'(1);
            end
        endcase
    end

    assign rng_e_m1 = rng_e - COUNT_W'(1);
    assign rng_go   = rng_s < rng_e;

    assign lo_eff    = first_reg ? lo_bit_reg : 5'd0;
    assign hi_eff    = (cur_word_reg == last_word_reg) ? hi_bit_reg : 5'd31;
    assign word_mask = range_mask(lo_eff, hi_eff);
    assign zero_bit  = lowest_zero(ram_rdata);
    assign wrap_word = (cur_word_reg == LAST_WORD) ? '0 : cur_word_reg + WW'(1);

    always_comb
    begin
        state_next       = state_reg;
        cur_word_next    = cur_word_reg;
        last_word_next   = last_word_reg;
        scan_cnt_next    = scan_cnt_reg;
        search_word_next = search_word_reg;
        lo_bit_next      = lo_bit_reg;
        hi_bit_next      = hi_bit_reg;
        first_next       = first_reg;
        set_next         = set_reg;
        fill_rsp_next    = fill_rsp_reg;
        used_next        = used_reg;
        total_next       = total_reg;
        status_next      = status_reg;
        alloc_addr_next  = alloc_addr_reg;
        ram_re           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = cur_word_reg;
        ram_wdata        = WORD_FULL;

        unique case (state_reg)
            S_FILL:
            begin
                ram_we = 1'b1;
                if (cur_word_reg == LAST_WORD)
                begin
                    cur_word_next = '0;
                    state_next    = fill_rsp_reg ? S_RESP : S_IDLE;
                end
                else
                begin
                    cur_word_next = cur_word_reg + WW'(1);
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    status_next     = STATUS_OK;
                    alloc_addr_next = '0;
                    // Latch the range; only used where a range command proceeds
                    cur_word_next   = rng_s[FW-1:5];
                    last_word_next  = rng_e_m1[FW-1:5];
                    lo_bit_next     = rng_s[4:0];
                    hi_bit_next     = rng_e_m1[4:0];
                    first_next      = 1'b1;
                    set_next        = (cmd.req_type == REQ_RESERVE_LOW);
                    state_next      = S_RESP;
                    unique case (cmd.req_type)
                        REQ_BEGIN_INIT:
                        begin
                            cur_word_next    = '0;
                            fill_rsp_next    = 1'b1;
                            search_word_next = '0;
                            used_next        = '0;
                            total_next       = '0;
                            state_next       = S_FILL;
                        end
                        REQ_ADD_REGION:
                        begin
                            if (cmd.region_kind == KIND_USABLE)
                            begin
                                total_next = sat_add(total_reg, {1'b0, frame_cnt});
                                if (rng_go)
                                begin
                                    state_next = S_RANGE_RD;
                                end
                            end
                        end
                        REQ_RESERVE_LOW:
                        begin
                            used_next = sat_add(used_reg, COUNT_W'(reserved_frames));
                            if (rng_go)
                            begin
                                state_next = S_RANGE_RD;
                            end
                        end
                        REQ_ALLOC:
                        begin
                            cur_word_next = search_word_reg;
                            scan_cnt_next = '0;
                            state_next    = S_SCAN_RD;
                        end
                        REQ_FREE:
                        begin
                            if (!free_in_map)
                            begin
                                status_next = STATUS_OUTSIDE;
                            end
                            else
                            begin
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - COUNT_W'(1);
                                end
                                state_next = S_RANGE_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_RANGE_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RANGE_WR;
            end

            S_RANGE_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = set_reg ? (ram_rdata | word_mask) : (ram_rdata & ~word_mask);
                first_next = 1'b0;
                if (cur_word_reg == last_word_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cur_word_next = cur_word_reg + WW'(1);
                    state_next    = S_RANGE_RD;
                end
            end

            S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (ram_rdata != WORD_FULL)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = ram_rdata | (32'd1 << zero_bit);
                    search_word_next = cur_word_reg;
                    alloc_addr_next  = 32'({cur_word_reg, zero_bit}) << FRAME_SHIFT;
                    used_next        = sat_add(used_reg, COUNT_W'(1));
                    state_next       = S_RESP;
                end
                else if (scan_cnt_reg == LAST_WORD)
                begin
                    status_next = STATUS_NO_MEM;
                    state_next  = S_RESP;
                end
                else
                begin
                    cur_word_next = wrap_word;
                    scan_cnt_next = scan_cnt_reg + WW'(1);
                    state_next    = S_SCAN_RD;
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    fill_rsp_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            cur_word_reg    <= '0;
            last_word_reg   <= '0;
            scan_cnt_reg    <= '0;
            search_word_reg <= '0;
            lo_bit_reg      <= '0;
            hi_bit_reg      <= '0;
            first_reg       <= 1'b0;
            set_reg         <= 1'b0;
            fill_rsp_reg    <= 1'b0;
            used_reg        <= '0;
            total_reg       <= '0;
            status_reg      <= STATUS_OK;
            alloc_addr_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_word_reg    <= cur_word_next;
            last_word_reg   <= last_word_next;
            scan_cnt_reg    <= scan_cnt_next;
            search_word_reg <= search_word_next;
            lo_bit_reg      <= lo_bit_next;
            hi_bit_reg      <= hi_bit_next;
            first_reg       <= first_next;
            set_reg         <= set_next;
            fill_rsp_reg    <= fill_rsp_next;
            used_reg        <= used_next;
            total_reg       <= total_next;
            status_reg      <= status_next;
            alloc_addr_reg  <= alloc_addr_next;
        end
    end

    assign cmd_ready         = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_RESP);
    assign res.status        = status_reg;
    assign res.alloc_address = alloc_addr_reg;
    assign res.used_count    = used_reg;
    assign res.total_count   = total_reg;

endmodule

### src/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: channels, register port, result register.
//
//  channel | direction | handshake        | carries
//  --------+-----------+------------------+----------------------------------------------
//  req     | in        | valid/ready      | req_type, address, region_size, region_kind
//  rsp     | out       | valid/ready      | status, alloc_address, used_count, total_count
//  apb     | in        | psel/penable     | reserved_frames at byte address 0
//
//  Steps per transaction, all on the single port of the bitmap memory:
//    alloc: read and check words from the next-fit word on until one has a free bit (up to MAP_WORDS).
//    add_region, reserve_low, free: read, modify and write back each bitmap word touched, if any.
//    begin_init: a sweep writes ones to every word, one word a cycle; unknown requests: straight to the response.
//  Reset: a fill sweep sets every word; req.ready stays low until done.
//  A finished result waits in the output register while the next request is taken.
module bitmap_frame_allocator #(
    parameter int MAP_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    bfa_req_if.sink     req,
    bfa_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfa_pkg::*;

    localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [10:0]   reserved_reg;
    cmd_t          cmd;
    logic          cmd_ready;
    logic          eng_res_valid;
    logic          eng_res_ready;
    rsp_t          eng_res;
    logic          out_valid_reg;
    rsp_t          out_data_reg;
    logic          ram_re;
    logic          ram_we;
    logic [WW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    // Register port: zero wait states, one register decoded on bit 2
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESERVED_FRAMES) ? {21'b0, reserved_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= RESERVED_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_RESERVED_FRAMES))
        begin
            reserved_reg <= pwdata[10:0];
        end
    end

    // Request transaction straight into the sequencer
    assign cmd.req_type    = req.req_type;
    assign cmd.address     = req.address;
    assign cmd.region_size = req.region_size;
    assign cmd.region_kind = req.region_kind;
    assign req.ready       = cmd_ready;

    bfa_engine #(
        .MAP_WORDS (MAP_WORDS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (req.valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .reserved_frames (reserved_reg),
        .res_valid       (eng_res_valid),
        .res_ready       (eng_res_ready),
        .res             (eng_res),
        .ram_re          (ram_re),
        .ram_we          (ram_we),
        .ram_addr        (ram_addr),
        .ram_wdata       (ram_wdata),
        .ram_rdata       (ram_rdata)
    );

    bfa_map_ram #(
        .MAP_WORDS (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .re    (ram_re),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Output register: take a new result when empty or being drained
    assign eng_res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_res_ready)
        begin
            out_valid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid && eng_res_ready)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_data_reg.status;
    assign rsp.alloc_address = out_data_reg.alloc_address;
    assign rsp.used_count    = out_data_reg.used_count;
    assign rsp.total_count   = out_data_reg.total_count;

    // One request in flight: the sequencer leaves idle on every accepted transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in flight");

    // Out of memory never reports an address
    a_no_mem_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STATUS_NO_MEM |-> rsp.alloc_address == 32'b0)
        else $error("out of memory with non-zero address");

    // A claimed frame is frame aligned and reported as ok
    a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.alloc_address != 32'b0
            |-> rsp.alloc_address[11:0] == 12'b0 && rsp.status == STATUS_OK)
        else $error("claimed frame address malformed");

    // Counters stay saturated
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.used_count <= COUNT_MAX && rsp.total_count <= COUNT_MAX)
        else $error("frame count beyond saturation limit");

endmodule

### tb/bitmap_frame_allocator_tb.sv
// Self-checking testbench of the bitmap frame allocator: random transactions against a scoreboard.
module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    localparam int MAP_WORDS     = 1024;
    localparam int MAP_FRAMES    = MAP_WORDS * 32;
    localparam int ITEM_BUDGET   = 1250;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int SAT_RESERVES  = 1026;

    // Request codes the block does not know; it must answer them and change nothing
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    // Byte address of the reserved_frames register
    localparam logic [2:0] RESERVE_ADDR = {REG_RESERVED_FRAMES, 2'b00};

    typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RSP_STALL, PACE_BOTH} pace_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    bitmap_frame_allocator #(.MAP_WORDS(MAP_WORDS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the allocator: bitmap, next-fit pointer, counters, register
    // ------------------------------------------------------------------
    logic [31:0] frame_bits [MAP_WORDS];
    int unsigned next_fit_word;
    logic [20:0] frames_used;
    logic [20:0] frames_total;
    logic [10:0] low_reserve;

    // Commands waiting for the driver, replies waiting for the block
    cmd_t cmds_to_send [$];
    rsp_t replies_due [$];
    int   cmds_queued;
    int   cmds_taken;
    int   fail_count;

    // Pacing of both channels and the long receiver hold-off
    int unsigned send_idle_pct;
    int unsigned rsp_stall_pct;
    bit          pressure_on = 1'b0;
    int          hold_left   = HOLD_CYCLES;

    // Generator's view of the frames it has handed to the block in this session
    int unsigned region_first [$];
    int unsigned region_count [$];
    int          frames_avail;

    cmd_t drive_cmd;
    cmd_t seen_cmd;
    rsp_t want;

    // Counters stick at COUNT_MAX rather than wrap
    function automatic logic [20:0] count_add(input logic [20:0] a, input logic [20:0] b);
        logic [21:0] s;
        s = a + b;
        return (s > COUNT_MAX) ? COUNT_MAX : s[20:0];
    endfunction

    // Every frame used, pointer and counters back to zero
    function automatic void clear_map();
        foreach (frame_bits[w])
        begin
            frame_bits[w] = WORD_FULL;
        end
        next_fit_word = 0;
        frames_used   = '0;
        frames_total  = '0;
    endfunction

    // Apply one command to the shadow state and return the reply it must produce
    function automatic rsp_t next_reply(input cmd_t c);
        rsp_t        r;
        int unsigned first;
        int unsigned stop;
        int unsigned w;
        int unsigned f;
        int unsigned b;
        logic [20:0] n;
        bit          found;
        r = '0;
        case (c.req_type)
            REQ_BEGIN_INIT:
                clear_map();
            REQ_ADD_REGION:
                if (c.region_kind == KIND_USABLE)
                begin
                    // Whole frames only; the part past the map still counts toward the total
                    first = c.address >> FRAME_SHIFT;
                    n = 21'(c.region_size >> FRAME_SHIFT);
                    frames_total = count_add(frames_total, n);
                    stop = first + n;
                    if (stop > MAP_FRAMES)
                    begin
                        stop = MAP_FRAMES;
                    end
                    for (f = first; f < stop; f++)
                    begin
                        frame_bits[f / 32][f % 32] = 1'b0;
                    end
                end
            REQ_RESERVE_LOW:
            begin
                for (f = 0; f < low_reserve && f < MAP_FRAMES; f++)
                begin
                    frame_bits[f / 32][f % 32] = 1'b1;
                end
                frames_used = count_add(frames_used, 21'(low_reserve));
            end
            REQ_ALLOC:
            begin
                // Next fit: start at the word of the last hit, skip full words, wrap once
                found = 1'b0;
                for (int i = 0; i < MAP_WORDS && !found; i++)
                begin
                    w = (next_fit_word + i) % MAP_WORDS;
                    if (frame_bits[w] != WORD_FULL)
                    begin
                        b = 0;
                        while (frame_bits[w][b])
                        begin
                            b++;
                        end
                        frame_bits[w][b] = 1'b1;
                        next_fit_word = w;
                        r.alloc_address = ((w << 5) | b) << FRAME_SHIFT;
                        frames_used = count_add(frames_used, 21'd1);
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    r.status = STATUS_NO_MEM;
                end
            end
            REQ_FREE:
            begin
                // A free of a free frame still drops the count, down to zero at most
                f = c.address >> FRAME_SHIFT;
                if (f >= MAP_FRAMES)
                begin
                    r.status = STATUS_OUTSIDE;
                end
                else
                begin
                    frame_bits[f / 32][f % 32] = 1'b0;
                    if (frames_used != '0)
                    begin
                        frames_used = frames_used - 21'd1;
                    end
                end
            end
            default:
                ;
        endcase
        r.used_count  = frames_used;
        r.total_count = frames_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and known levels on every input from time zero
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_BEGIN_INIT;
        req_ch.address     = '0;
        req_ch.region_size = '0;
        req_ch.region_kind = '0;
        rsp_ch.ready       = 1'b0;
        send_idle_pct      = 0;
        rsp_stall_pct      = 0;
        clear_map();
        low_reserve = RESERVED_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offer the next queued command whenever the bus is free
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_cmd = cmds_to_send.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.req_type    <= drive_cmd.req_type;
                req_ch.address     <= drive_cmd.address;
                req_ch.region_size <= drive_cmd.region_size;
                req_ch.region_kind <= drive_cmd.region_kind;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver, counted here while pressure is on
    always @(posedge clk)
    begin
        if (!pressure_on)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= rst_n && !(pressure_on && hold_left != 0)
                        && $urandom_range(99) >= rsp_stall_pct;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted command, check each accepted reply
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen_cmd.req_type    = req_ch.req_type;
                seen_cmd.address     = req_ch.address;
                seen_cmd.region_size = req_ch.region_size;
                seen_cmd.region_kind = req_ch.region_kind;
                replies_due.push_back(next_reply(seen_cmd));
                cmds_taken++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.alloc_address !== want.alloc_address)
                    begin
                        $error("alloc_address: expected %h, got %h",
                               want.alloc_address, rsp_ch.alloc_address);
                        fail_count++;
                    end
                    if (rsp_ch.used_count !== want.used_count)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.used_count, rsp_ch.used_count);
                        fail_count++;
                    end
                    if (rsp_ch.total_count !== want.total_count)
                    begin
                        $error("total_count: expected %0d, got %0d",
                               want.total_count, rsp_ch.total_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Queue one command for the driver
    function automatic void queue_cmd(input logic [2:0] op, input logic [31:0] addr,
                                      input logic [31:0] len, input logic [7:0] kind);
        cmd_t c;
        c.req_type    = op;
        c.address     = addr;
        c.region_size = len;
        c.region_kind = kind;
        cmds_to_send.push_back(c);
        cmds_queued++;
    endfunction

    function automatic void set_pace(input pace_t pace);
        case (pace)
            PACE_FULL:      begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            PACE_SEND_IDLE: begin send_idle_pct = 57; rsp_stall_pct = 0;  end
            PACE_RSP_STALL: begin send_idle_pct = 0;  rsp_stall_pct = 57; end
            default:        begin send_idle_pct = 8;  rsp_stall_pct = 8;  end
        endcase
    endfunction

    // Free a usable region above the largest reserve, so allocations have room
    function automatic void add_usable_region();
        int unsigned first;
        int unsigned n;
        first = $urandom_range(32, MAP_WORDS - 4) * 32 + $urandom_range(0, 31);
        n = ($urandom_range(9) == 0) ? $urandom_range(65, 2048) : $urandom_range(1, 64);
        region_first.push_back(first);
        region_count.push_back(n);
        frames_avail += (first + n > MAP_FRAMES) ? MAP_FRAMES - first : n;
        queue_cmd(REQ_ADD_REGION, first << FRAME_SHIFT,
                  (n << FRAME_SHIFT) | $urandom_range(0, 4095), KIND_USABLE);
    endfunction

    // Hold until every command is taken and answered, then let the block settle
    task automatic wait_idle();
        while (cmds_taken != cmds_queued || replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write reserved_frames, then read it back over a second transfer
    task automatic set_reserve(input logic [10:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RESERVE_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        low_reserve = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[10:0] !== value)
        begin
            $error("reserved_frames: expected %0d, got %0d", value, prdata[10:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed corners, random sessions, counter saturation
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          session;
        int          ops;
        int          pick;
        int unsigned n;
        int unsigned first;
        int unsigned idx;
        logic [2:0]  op;

        set_pace(PACE_FULL);

        // Map is full straight after reset: the first alloc must run out of memory
        queue_cmd(REQ_ALLOC, 32'h0, 32'h0, 8'h00);
        queue_cmd(REQ_FREE, 32'hFFFF_F000, 32'hFFFF_FFFF, 8'hFF);
        // Nothing used yet: the free must leave the count at zero
        queue_cmd(REQ_FREE, 32'h0000_0000, 32'h0, 8'h00);
        queue_cmd(REQ_UNKNOWN_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        queue_cmd(REQ_UNKNOWN_HI, 32'h0000_0000, 32'h0000_0000, 8'h01);
        // Region kinds other than usable RAM are ignored
        queue_cmd(REQ_ADD_REGION, 32'h0040_0000, 32'h0001_0000, 8'h00);
        queue_cmd(REQ_ADD_REGION, 32'h0040_0000, 32'h0001_0000, 8'hFF);
        // Wholly past the map, then straddling its end with a partial frame
        queue_cmd(REQ_ADD_REGION, 32'h0800_0000, 32'h0000_8000, KIND_USABLE);
        queue_cmd(REQ_ADD_REGION, 32'h07FF_8000, 32'h0001_0FFF, KIND_USABLE);
        queue_cmd(REQ_ADD_REGION, 32'h0000_0000, 32'h0000_0FFF, KIND_USABLE);
        queue_cmd(REQ_ADD_REGION, 32'h0040_0000, 32'h0004_0000, KIND_USABLE);
        queue_cmd(REQ_RESERVE_LOW, 32'h0, 32'h0, 8'h00);
        queue_cmd(REQ_ALLOC, 32'h0, 32'h0, 8'h00);
        queue_cmd(REQ_ALLOC, 32'h0, 32'h0, 8'h00);
        // Free a claimed frame, then the same frame again
        queue_cmd(REQ_FREE, 32'h0040_0000, 32'h0, 8'h00);
        queue_cmd(REQ_FREE, 32'h0040_0000, 32'h0, 8'h00);
        queue_cmd(REQ_FREE, 32'h07FF_FFFF, 32'h0, 8'h00);
        queue_cmd(REQ_FREE, 32'h0800_0000, 32'h0, 8'h00);
        // Largest possible region twice: the total sticks at its ceiling
        queue_cmd(REQ_ADD_REGION, 32'hFFFF_F000, 32'hFFFF_FFFF, KIND_USABLE);
        queue_cmd(REQ_ADD_REGION, 32'hFFFF_F000, 32'hFFFF_FFFF, KIND_USABLE);
        queue_cmd(REQ_BEGIN_INIT, 32'h0, 32'h0, 8'h00);
        queue_cmd(REQ_ALLOC, 32'h0, 32'h0, 8'h00);
        queue_cmd(REQ_RESERVE_LOW, 32'h0, 32'h0, 8'h00);

        // Leave room in the budget for the saturation run at the end
        session = 0;
        while (cmds_queued < ITEM_BUDGET - SAT_RESERVES - 3)
        begin
            wait_idle();
            pressure_on = 1'b0;
            if (session % 5 == 0)
            begin
                case ((session / 5) % 4)
                    0:       set_reserve(11'd1024);
                    1:       set_reserve(11'd0);
                    2:       set_reserve(11'($urandom_range(1, 1023)));
                    default: set_reserve(RESERVED_RESET);
                endcase
            end
            set_pace(pace_t'(session % 4));
            // Keep the sender busy while the receiver sits on its hands
            if (session % 13 == 5)
            begin
                set_pace(PACE_FULL);
                pressure_on = 1'b1;
            end
            region_first.delete();
            region_count.delete();
            frames_avail = 0;

            if (session % 9 == 7)
            begin
                // Drain a small region dry: the last two allocs find nothing
                n = $urandom_range(1, 40);
                first = $urandom_range(32, MAP_WORDS - 2) * 32 + $urandom_range(0, 31);
                queue_cmd(REQ_BEGIN_INIT, $urandom, $urandom, 8'($urandom));
                queue_cmd(REQ_ADD_REGION, first << FRAME_SHIFT, n << FRAME_SHIFT, KIND_USABLE);
                queue_cmd(REQ_RESERVE_LOW, $urandom, $urandom, 8'($urandom));
                repeat (n + 2) queue_cmd(REQ_ALLOC, $urandom, $urandom, 8'($urandom));
            end
            else
            begin
                if ($urandom_range(2) == 0)
                begin
                    queue_cmd(REQ_BEGIN_INIT, $urandom, $urandom, 8'($urandom));
                end
                repeat ($urandom_range(1, 3)) add_usable_region();
                queue_cmd(REQ_RESERVE_LOW, $urandom, $urandom, 8'($urandom));
                ops = $urandom_range(4, 16);
                repeat (ops)
                begin
                    pick = $urandom_range(99);
                    if (pick < 45 && frames_avail > 0)
                    begin
                        queue_cmd(REQ_ALLOC, $urandom, $urandom, 8'($urandom));
                        frames_avail--;
                    end
                    else if (pick < 72)
                    begin
                        // Mostly frames of this session's regions, sometimes a reserved one
                        if (region_first.size() == 0 || $urandom_range(7) == 0)
                        begin
                            first = $urandom_range(0, 1023);
                        end
                        else
                        begin
                            idx = $urandom_range(region_first.size() - 1);
                            first = region_first[idx] + $urandom_range(region_count[idx] - 1);
                        end
                        queue_cmd(REQ_FREE, (first << FRAME_SHIFT) | $urandom_range(0, 4095),
                                  $urandom, 8'($urandom));
                    end
                    else if (pick < 77)
                    begin
                        first = $urandom_range(MAP_FRAMES, 32'h000F_FFFF);
                        queue_cmd(REQ_FREE, (first << FRAME_SHIFT) | $urandom_range(0, 4095),
                                  $urandom, 8'($urandom));
                    end
                    else if (pick < 88)
                    begin
                        // Noise: random fields on a region, a free or an unknown code
                        idx = $urandom_range(0, 4);
                        if (idx == 0)
                        begin
                            op = REQ_ADD_REGION;
                        end
                        else if (idx == 1)
                        begin
                            op = REQ_FREE;
                        end
                        else
                        begin
                            op = REQ_UNKNOWN_LO + 3'(idx - 2);
                        end
                        queue_cmd(op, $urandom, $urandom, 8'($urandom));
                    end
                    else if (pick < 96)
                    begin
                        add_usable_region();
                    end
                    else
                    begin
                        queue_cmd(REQ_RESERVE_LOW, $urandom, $urandom, 8'($urandom));
                    end
                end
            end
            session++;
        end

        // Push the used count into its ceiling with the largest reserve, then step off it
        wait_idle();
        pressure_on = 1'b0;
        set_pace(PACE_FULL);
        set_reserve(11'd1024);
        queue_cmd(REQ_BEGIN_INIT, 32'h0, 32'h0, 8'h00);
        repeat (SAT_RESERVES) queue_cmd(REQ_RESERVE_LOW, $urandom, $urandom, 8'($urandom));
        queue_cmd(REQ_FREE, 32'h0000_5000, 32'h0, 8'h00);
        queue_cmd(REQ_ALLOC, 32'h0, 32'h0, 8'h00);
        queue_cmd(REQ_ALLOC, 32'h0, 32'h0, 8'h00);

        wait_idle();
        if (fail_count == 0 && replies_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: several times the slowest expected run
    initial
    begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
